### design/pms_pkg.sv
// ============================================================================
// pms_pkg
// Shared sizes, codes and types for the Potts Metropolis site update block.
// ============================================================================
package pms_pkg;

  // Lattice geometry (power-of-two sides, site address is {row, col})
  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int ROWS   = 1 << ROW_W;
  localparam int COLS   = 1 << COL_W;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = ROWS * COLS;

  // Spin states
  localparam int STATE_W    = 4;
  localparam int MAX_STATE  = 8;
  localparam int INIT_STATE = 3;

  // Acceptance test
  localparam int THR_W  = 17;
  localparam int DRAW_W = 16;
  localparam int NB_MAX = 6;
  localparam int CNT_W  = 3;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 17;
  localparam logic [CFG_IDX_W-1:0] REG_LATTICE_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_THR_FIRST    = CFG_IDX_W'(1);

  // Lattice mode codes (the unused code behaves as square)
  localparam logic [1:0] MODE_SQUARE = 2'd0;
  localparam logic [1:0] MODE_TRI    = 2'd1;
  localparam logic [1:0] MODE_HEX    = 2'd2;

  // Item commands
  localparam logic CMD_PROPOSE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  // Read slots: neighbours first, then the site itself
  localparam int SLOT_W = 3;
  typedef logic [SLOT_W-1:0] slot_t;
  localparam slot_t SLOT_N0     = slot_t'(0);
  localparam slot_t SLOT_N1     = slot_t'(1);
  localparam slot_t SLOT_N2     = slot_t'(2);
  localparam slot_t SLOT_N3     = slot_t'(3);
  localparam slot_t SLOT_N4     = slot_t'(4);
  localparam slot_t SLOT_N5     = slot_t'(5);
  localparam slot_t SLOT_CENTRE = slot_t'(NB_MAX);

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_LAST,
    ST_DECIDE
  } fsm_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the input transaction
    logic issue;   // issue a grid read for the current slot
    logic finish;  // write back and load the result register
    logic clr_wr;  // clearing pass write
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_centre;  // current slot is the site itself
    logic clr_last;     // clearing pass at its final entry
  } dp_stat_t;

endpackage

### design/pms_ram.sv
// ============================================================================
// pms_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module pms_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/pms_dpath.sv
// ============================================================================
// pms_dpath
// Datapath: config registers, item capture, neighbour addressing, grid RAM,
// unlike-neighbour count, acceptance test and result register.
// ============================================================================
module pms_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pms_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pms_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                in_cmd,
  input  logic [pms_pkg::ROW_W-1:0]           in_row,
  input  logic [pms_pkg::COL_W-1:0]           in_col,
  input  logic [pms_pkg::STATE_W-1:0]         in_proposed_state,
  input  logic [pms_pkg::DRAW_W-1:0]          in_random_draw,
  input  pms_pkg::ctrl_cmd_t                  cmd,
  output pms_pkg::dp_stat_t                   stat,
  output logic                                out_accepted,
  output logic [pms_pkg::STATE_W-1:0]         out_site_state,
  output logic [pms_pkg::CNT_W-1:0]           out_unlike_count
);

  // Configuration registers
  logic [1:0]                  mode_r;
  logic [pms_pkg::THR_W-1:0]   thr_r [pms_pkg::NB_MAX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pms_pkg::MODE_SQUARE;
      for (int k = 0; k < pms_pkg::NB_MAX; k++) begin
        thr_r[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == pms_pkg::REG_LATTICE_MODE) begin
        mode_r <= cfg_wdata[1:0];
      end
      for (int k = 0; k < pms_pkg::NB_MAX; k++) begin
        if (cfg_index == pms_pkg::CFG_IDX_W'(k + 1)) begin
          thr_r[k] <= cfg_wdata[pms_pkg::THR_W-1:0];
        end
      end
    end
  end

  // Captured transaction
  logic                          cmd_r;
  logic [pms_pkg::ROW_W-1:0]     row_r;
  logic [pms_pkg::COL_W-1:0]     col_r;
  logic [pms_pkg::STATE_W-1:0]   cand_r;
  logic [pms_pkg::DRAW_W-1:0]    draw_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      row_r  <= in_row;
      col_r  <= in_col;
      cand_r <= in_proposed_state;
      draw_r <= in_random_draw;
    end
  end

  // Last neighbour slot for the active pattern
  pms_pkg::slot_t nb_last;

  always_comb begin
    unique case (mode_r)
      pms_pkg::MODE_TRI: nb_last = pms_pkg::SLOT_N5;
      pms_pkg::MODE_HEX: nb_last = pms_pkg::SLOT_N2;
      default:           nb_last = pms_pkg::SLOT_N3;
    endcase
  end

  // Slot sequencer
  pms_pkg::slot_t slot_r, slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (cmd.load) begin
      slot_nxt = (in_cmd == pms_pkg::CMD_READ) ? pms_pkg::SLOT_CENTRE : pms_pkg::SLOT_N0;
    end else if (cmd.issue) begin
      slot_nxt = (slot_r == nb_last) ? pms_pkg::SLOT_CENTRE : slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= pms_pkg::SLOT_CENTRE;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign stat.slot_centre = (slot_r == pms_pkg::SLOT_CENTRE);

  // Wrapped neighbour coordinates
  logic [pms_pkg::ROW_W-1:0] row_p, row_m;
  logic [pms_pkg::COL_W-1:0] col_p, col_m, col_d, col_e;

  assign row_p = (row_r == pms_pkg::ROW_W'(pms_pkg::ROWS - 1)) ? '0 : row_r + 1'b1;
  assign row_m = (row_r == '0) ? pms_pkg::ROW_W'(pms_pkg::ROWS - 1) : row_r - 1'b1;
  assign col_p = (col_r == pms_pkg::COL_W'(pms_pkg::COLS - 1)) ? '0 : col_r + 1'b1;
  assign col_m = (col_r == '0) ? pms_pkg::COL_W'(pms_pkg::COLS - 1) : col_r - 1'b1;
  // diagonal offset by row parity, hexagonal offset by site parity
  assign col_d = row_r[0] ? col_m : col_p;
  assign col_e = (row_r[0] ^ col_r[0]) ? col_m : col_p;

  logic [pms_pkg::ADDR_W-1:0] rd_addr;

  always_comb begin
    unique case (slot_r)
      pms_pkg::SLOT_N0: rd_addr = {row_p, col_r};
      pms_pkg::SLOT_N1: rd_addr = {row_m, col_r};
      pms_pkg::SLOT_N2: rd_addr = (mode_r == pms_pkg::MODE_HEX) ? {row_r, col_e}
                                                                 : {row_r, col_m};
      pms_pkg::SLOT_N3: rd_addr = {row_r, col_p};
      pms_pkg::SLOT_N4: rd_addr = {row_p, col_d};
      pms_pkg::SLOT_N5: rd_addr = {row_m, col_d};
      default:          rd_addr = {row_r, col_r};
    endcase
  end

  // Clearing pass counter
  logic [pms_pkg::ADDR_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign stat.clr_last = (clr_cnt_r == '1);

  // Grid memory
  logic                          acc;
  logic                          ram_we;
  logic [pms_pkg::ADDR_W-1:0]    ram_waddr;
  logic [pms_pkg::STATE_W-1:0]   ram_wdata;
  logic [pms_pkg::STATE_W-1:0]   rdata;

  assign ram_we    = cmd.clr_wr | (cmd.finish & acc);
  assign ram_waddr = cmd.clr_wr ? clr_cnt_r : {row_r, col_r};
  assign ram_wdata = cmd.clr_wr ? pms_pkg::STATE_W'(pms_pkg::INIT_STATE) : cand_r;

  pms_ram #(
    .WIDTH (pms_pkg::STATE_W),
    .DEPTH (pms_pkg::DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.issue),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Returning read data, tagged with its slot
  pms_pkg::slot_t                tag_r;
  logic                          tag_vld_r;
  logic [pms_pkg::CNT_W-1:0]     count_r;
  logic [pms_pkg::STATE_W-1:0]   centre_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_vld_r <= 1'b0;
    end else begin
      tag_vld_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      tag_r <= slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      count_r <= '0;
    end else if (tag_vld_r && tag_r != pms_pkg::SLOT_CENTRE) begin
      count_r <= count_r + pms_pkg::CNT_W'(rdata != cand_r);
    end
  end

  always_ff @(posedge clk) begin
    if (tag_vld_r && tag_r == pms_pkg::SLOT_CENTRE) begin
      centre_r <= rdata;
    end
  end

  // Acceptance test
  logic [pms_pkg::THR_W-1:0] thr_sel;
  logic                      cand_ok;

  always_comb begin
    thr_sel = '0;
    for (int k = 0; k < pms_pkg::NB_MAX; k++) begin
      if (count_r == pms_pkg::CNT_W'(k + 1)) begin
        thr_sel = thr_r[k];
      end
    end
  end

  assign cand_ok = (cand_r != '0) && (cand_r <= pms_pkg::STATE_W'(pms_pkg::MAX_STATE));
  assign acc     = (cmd_r == pms_pkg::CMD_PROPOSE) && cand_ok &&
                   ((count_r == '0) || ({1'b0, draw_r} < thr_sel));

  // Result register
  logic                          acc_out_r;
  logic [pms_pkg::STATE_W-1:0]   state_out_r;
  logic [pms_pkg::CNT_W-1:0]     count_out_r;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      acc_out_r   <= acc;
      state_out_r <= acc ? cand_r : centre_r;
      count_out_r <= count_r;
    end
  end

  assign out_accepted     = acc_out_r;
  assign out_site_state   = state_out_r;
  assign out_unlike_count = count_out_r;

endmodule

### design/pms_ctrl.sv
// ============================================================================
// pms_ctrl
// Controller: clearing pass, read sequencing, decision and output handshake.
// ============================================================================
module pms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pms_pkg::dp_stat_t   stat,
  output pms_pkg::ctrl_cmd_t  cmd
);

  pms_pkg::fsm_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pms_pkg::ST_CLEAR:  if (stat.clr_last)    state_nxt = pms_pkg::ST_IDLE;
      pms_pkg::ST_IDLE:   if (in_valid)         state_nxt = pms_pkg::ST_ISSUE;
      pms_pkg::ST_ISSUE:  if (stat.slot_centre) state_nxt = pms_pkg::ST_LAST;
      pms_pkg::ST_LAST:                         state_nxt = pms_pkg::ST_DECIDE;
      pms_pkg::ST_DECIDE: if (out_free)         state_nxt = pms_pkg::ST_IDLE;
      default:                                  state_nxt = pms_pkg::ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      pms_pkg::ST_CLEAR:  cmd.clr_wr = 1'b1;
      pms_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      pms_pkg::ST_ISSUE:  cmd.issue  = 1'b1;
      pms_pkg::ST_LAST:   cmd        = '0;
      pms_pkg::ST_DECIDE: cmd.finish = out_free;
      default:            cmd        = '0;
    endcase
  end

  // Result valid: set on finish, dropped once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pms_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### design/potts_metropolis_site_update.sv
// ============================================================================
// potts_metropolis_site_update
// Metropolis spin update on a toroidal Potts grid held in one block RAM.
// ============================================================================
// Each transaction makes one grid read per neighbour and one for the site,
//   all on the single read port; a read command reads the site only.
// Flow: one transaction in work at a time; the result register
//   lets the next transaction start while a result waits.
// Reset: synchronous, active low; config clears to zero, then a clearing pass
//   fills all 4096 grid entries with the initial state before in_ready rises.
module potts_metropolis_site_update (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pms_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_cmd,
  input  logic [pms_pkg::ROW_W-1:0]          in_row,
  input  logic [pms_pkg::COL_W-1:0]          in_col,
  input  logic [pms_pkg::STATE_W-1:0]        in_proposed_state,
  input  logic [pms_pkg::DRAW_W-1:0]         in_random_draw,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_accepted,
  output logic [pms_pkg::STATE_W-1:0]        out_site_state,
  output logic [pms_pkg::CNT_W-1:0]          out_unlike_count
);

  pms_pkg::ctrl_cmd_t cmd;
  pms_pkg::dp_stat_t  stat;

  // Sequencing
  pms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Grid and arithmetic
  pms_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_cmd            (in_cmd),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_proposed_state (in_proposed_state),
    .in_random_draw    (in_random_draw),
    .cmd               (cmd),
    .stat              (stat),
    .out_accepted      (out_accepted),
    .out_site_state    (out_site_state),
    .out_unlike_count  (out_unlike_count)
  );

endmodule

### design/pms_checker.sv
// ============================================================================
// pms_checker
// Port-level checks for the Potts site update block, bound to the top level.
// ============================================================================
module pms_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_accepted,
  input logic [pms_pkg::STATE_W-1:0]        out_site_state,
  input logic [pms_pkg::CNT_W-1:0]          out_unlike_count
);

  // Stalled result holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_accepted) &&
      $stable(out_site_state) && $stable(out_unlike_count))
    else $error("result changed while stalled");

  // One transaction at a time: ready drops after each acceptance
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken during work");

  // Every reported site state is legal, as the grid holds only legal states once cleared
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_site_state != '0) &&
      (out_site_state <= pms_pkg::STATE_W'(pms_pkg::MAX_STATE)))
    else $error("illegal site state reported");

  // Count never exceeds the largest neighbourhood
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_unlike_count <= pms_pkg::CNT_W'(pms_pkg::NB_MAX))
    else $error("unlike count out of range");

endmodule

bind potts_metropolis_site_update pms_checker u_pms_checker (.*);

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: Potts Metropolis site update testbench
// A driver and a monitor run the valid/ready channels with random gaps and
// stalls. Each transaction is predicted at acceptance against a mirrored
// spin grid and configuration, and results are checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import pms_pkg::*;

  localparam int   RUN_LIMIT     = 400000;
  localparam int   SETTLE_CYCLES = 12;
  localparam int   PHASE_ITEMS   = 225;
  localparam int   LONG_HOLD     = 300;
  localparam int   THR_ONE       = 65536;
  localparam int   IDLE_HEAVY    = 45;
  localparam int   IDLE_BOTH     = 20;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);

  typedef enum logic [1:0] {PLAN_ZERO, PLAN_FULL, PLAN_RANDOM, PLAN_EDGE} thr_plan_t;

  typedef struct packed {
    logic               cmd;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [STATE_W-1:0] cand;
    logic [DRAW_W-1:0]  draw;
  } spin_item_t;

  typedef struct packed {
    logic               accepted;
    logic [STATE_W-1:0] site_state;
    logic [CNT_W-1:0]   unlike_count;
  } site_result_t;

  // DUT signals
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_cmd = CMD_PROPOSE;
  logic [ROW_W-1:0]     in_row = '0;
  logic [COL_W-1:0]     in_col = '0;
  logic [STATE_W-1:0]   in_proposed_state = '0;
  logic [DRAW_W-1:0]    in_random_draw = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_accepted;
  logic [STATE_W-1:0]   out_site_state;
  logic [CNT_W-1:0]     out_unlike_count;

  // Mirrored block state
  logic [STATE_W-1:0] spin_mirror [ROWS][COLS];
  logic [1:0]         lattice_sel = MODE_SQUARE;
  logic [THR_W-1:0]   accept_thr [1:NB_MAX] = '{default: '0};

  spin_item_t   pending_q [$];
  site_result_t expected_q [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_arm   = 1'b0;
  logic hold_fired = 1'b0;
  int   hold_left  = 0;
  int   err_count  = 0;
  int   cycle_count = 0;

  potts_metropolis_site_update uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_proposed_state (in_proposed_state),
    .in_random_draw    (in_random_draw),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_accepted      (out_accepted),
    .out_site_state    (out_site_state),
    .out_unlike_count  (out_unlike_count)
  );

  always #10 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---- Prediction ----
  function automatic logic unlike_at(input logic [STATE_W-1:0] cand,
                                     input logic [ROW_W-1:0] r,
                                     input logic [COL_W-1:0] c);
    return spin_mirror[r][c] != cand;
  endfunction

  // Counts unlike neighbours, applies the Metropolis test and updates the grid
  function automatic site_result_t metropolis_update(input spin_item_t it);
    site_result_t res;
    logic [ROW_W-1:0] r_dn, r_up;
    logic [COL_W-1:0] c_fw, c_bk, c_side;
    int cnt;
    r_dn = it.row + 1'b1;
    r_up = it.row - 1'b1;
    c_fw = it.col + 1'b1;
    c_bk = it.col - 1'b1;
    cnt  = 0;
    res  = '0;
    if (it.cmd == CMD_PROPOSE) begin
      cnt = unlike_at(it.cand, r_dn, it.col) + unlike_at(it.cand, r_up, it.col);
      if (lattice_sel == MODE_HEX) begin
        // side neighbour lies right on even row+col parity, left on odd
        c_side = (it.row[0] ^ it.col[0]) ? c_bk : c_fw;
        cnt += unlike_at(it.cand, it.row, c_side);
      end else begin
        cnt += unlike_at(it.cand, it.row, c_bk) + unlike_at(it.cand, it.row, c_fw);
        if (lattice_sel == MODE_TRI) begin
          c_side = it.row[0] ? c_bk : c_fw;
          cnt += unlike_at(it.cand, r_dn, c_side) + unlike_at(it.cand, r_up, c_side);
        end
      end
      if (it.cand >= 1 && it.cand <= MAX_STATE &&
          (cnt == 0 || int'(it.draw) < int'(accept_thr[cnt]))) begin
        res.accepted = 1'b1;
        spin_mirror[it.row][it.col] = it.cand;
      end
    end
    res.unlike_count = CNT_W'(cnt);
    res.site_state   = spin_mirror[it.row][it.col];
    return res;
  endfunction

  // ---- Driver ----
  always @(posedge clk) begin : spin_driver
    spin_item_t nxt;
    logic busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        expected_q.push_back(metropolis_update({in_cmd, in_row, in_col,
                                                in_proposed_state, in_random_draw}));
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_q.pop_front();
          in_cmd            <= nxt.cmd;
          in_row            <= nxt.row;
          in_col            <= nxt.col;
          in_proposed_state <= nxt.cand;
          in_random_draw    <= nxt.draw;
          in_valid          <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, fired once when armed
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      hold_fired <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_fired) begin
      hold_left  <= LONG_HOLD;
      hold_fired <= 1'b1;
    end
  end

  // ---- Monitor ----
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    site_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, accepted %0d state %0d count %0d", $time,
                   out_accepted, out_site_state, out_unlike_count);
          err_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("accepted", want.accepted, out_accepted);
          check_field("site_state", want.site_state, out_site_state);
          check_field("unlike_count", want.unlike_count, out_unlike_count);
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---- Stimulus ----
  function automatic void add_item(input logic cmd, input int r, input int c,
                                   input int cand, input int draw);
    pending_q.push_back({cmd, ROW_W'(r), COL_W'(c), STATE_W'(cand), DRAW_W'(draw)});
  endfunction

  function automatic spin_item_t random_item(input logic [ROW_W-1:0] rb,
                                             input logic [COL_W-1:0] cb);
    spin_item_t it;
    int pick;
    it.cmd = ($urandom_range(99) < 15) ? CMD_READ : CMD_PROPOSE;
    // mostly a small window so updates interact; it may straddle the wrap
    if ($urandom_range(99) < 70) begin
      it.row = ROW_W'(rb + $urandom_range(0, 7));
      it.col = COL_W'(cb + $urandom_range(0, 7));
    end else begin
      it.row = ROW_W'($urandom);
      it.col = COL_W'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 3)
      it.cand = '0;
    else if (pick < 10)
      it.cand = STATE_W'($urandom_range(MAX_STATE + 1, (1 << STATE_W) - 1));
    else if (pick < 55)
      it.cand = STATE_W'($urandom_range(1, 3));
    else
      it.cand = STATE_W'($urandom_range(1, MAX_STATE));
    pick = $urandom_range(99);
    if (pick < 8)
      it.draw = '0;
    else if (pick < 16)
      it.draw = '1;
    else
      it.draw = DRAW_W'($urandom);
    return it;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_LATTICE_MODE)
      lattice_sel = val[1:0];
    else if (idx <= CFG_IDX_W'(NB_MAX))
      accept_thr[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_config(input logic [1:0] mode, input thr_plan_t plan);
    logic [CFG_W-1:0] val;
    write_reg(REG_LATTICE_MODE, CFG_W'(mode));
    for (int k = 1; k <= NB_MAX; k++) begin
      case (plan)
        PLAN_ZERO:   val = '0;
        PLAN_FULL:   val = CFG_W'(THR_ONE);
        PLAN_RANDOM: val = CFG_W'($urandom_range(0, THR_ONE));
        default: begin
          // boundary values, including thresholds above one
          case (k)
            1:       val = CFG_W'(THR_ONE - 1);
            2:       val = CFG_W'(1);
            3:       val = CFG_W'(THR_ONE);
            4:       val = '1;
            5:       val = CFG_W'(THR_ONE / 2);
            default: val = CFG_W'(THR_ONE - 1);
          endcase
        end
      endcase
      write_reg(REG_THR_FIRST + CFG_IDX_W'(k - 1), val);
    end
  endtask

  // Hold the sender until every outstanding transaction has returned;
  // sampled on the falling edge so the driver's updates have settled
  task automatic drain();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [1:0]       mode;
    thr_plan_t        plan;
    logic [ROW_W-1:0] row_base;
    logic [COL_W-1:0] col_base;
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLS; c++)
        spin_mirror[r][c] = STATE_W'(INIT_STATE);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: square lattice, every threshold zero
    add_item(CMD_READ, 0, 0, 0, 0);
    add_item(CMD_PROPOSE, 0, 0, INIT_STATE, 16'hFFFF);   // no unlike neighbours
    add_item(CMD_PROPOSE, 0, 0, 5, 0);                   // zero threshold rejects
    add_item(CMD_PROPOSE, 63, 63, 0, 0);                 // candidate zero
    add_item(CMD_PROPOSE, 63, 0, 15, 0);                 // candidate above range
    add_item(CMD_PROPOSE, 32, 31, MAX_STATE + 1, 0);
    add_item(CMD_READ, 63, 63, 15, 16'hFFFF);
    add_item(CMD_PROPOSE, 21, 42, MAX_STATE, 16'hFFFF);
    add_item(CMD_PROPOSE, 42, 21, 1, 16'h5555);
    drain();

    // Triangular, every threshold one: any count passes
    program_config(MODE_TRI, PLAN_FULL);
    add_item(CMD_PROPOSE, 10, 10, 7, 16'hFFFF);          // six unlike
    add_item(CMD_PROPOSE, 10, 11, 7, 16'hFFFF);
    add_item(CMD_PROPOSE, 11, 10, 7, 16'hFFFF);          // odd row leans left
    add_item(CMD_PROPOSE, 0, 0, 1, 16'hFFFF);
    add_item(CMD_PROPOSE, 63, 63, 4, 16'hFFFF);
    add_item(CMD_READ, 10, 10, 0, 0);
    drain();

    // Hexagonal, boundary thresholds
    program_config(MODE_HEX, PLAN_EDGE);
    add_item(CMD_PROPOSE, 0, 0, 2, 16'hFFFF);
    add_item(CMD_PROPOSE, 0, 63, 2, 16'hFFFE);           // odd parity takes the left side
    add_item(CMD_PROPOSE, 63, 63, 6, 16'hFFFF);
    add_item(CMD_PROPOSE, 1, 0, 8, 0);
    add_item(CMD_PROPOSE, 0, 1, 2, 16'hFFFF);
    drain();

    // Random phases, each with its own configuration and idling pattern
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3)
        mode = MODE_UNUSED;
      else if (ph % 3 == 0)
        mode = MODE_SQUARE;
      else if (ph % 3 == 1)
        mode = MODE_TRI;
      else
        mode = MODE_HEX;
      case (ph)
        1, 6:    plan = PLAN_EDGE;
        3:       plan = PLAN_FULL;
        5:       plan = PLAN_ZERO;
        default: plan = PLAN_RANDOM;
      endcase
      program_config(mode, plan);
      if (ph == 3)
        write_reg(REG_UNUSED, CFG_W'($urandom));
      case (ph % 4)
        0: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  <= IDLE_HEAVY;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  <= 0;
          recv_stall_pct <= IDLE_HEAVY;
        end
        default: begin
          send_idle_pct  <= IDLE_BOTH;
          recv_stall_pct <= IDLE_BOTH;
        end
      endcase
      hold_arm <= (ph == 4);
      row_base = ROW_W'($urandom);
      col_base = COL_W'($urandom);
      for (int n = 0; n < PHASE_ITEMS; n++)
        pending_q.push_back(random_item(row_base, col_base));
      drain();
    end

    if (err_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### files.f
design/pms_pkg.sv
design/pms_ram.sv
design/pms_dpath.sv
design/pms_ctrl.sv
design/potts_metropolis_site_update.sv
design/pms_checker.sv
test/tb_top.sv
